// ===== rtl/i2c_master_bit_sequencer_defines.svh =====
// Assertion macros shared by the I2C bit sequencer RTL.
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define I2CBS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define I2CBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/i2cbs_pkg.sv =====
// Shared types and constants of the I2C master bit sequencer.
package i2cbs_pkg;

	localparam int unsigned QueueDepth = 2;

	localparam int unsigned S_TDATA_W = 16;
	localparam int unsigned M_TDATA_W = 16;
	localparam int unsigned CFG_DATA_W = 10;
	localparam int unsigned CFG_IDX_W = 2;

	// Command codes; the idle code is never a valid command.
	localparam logic [2:0] OP_START = 3'd0;
	localparam logic [2:0] OP_STOP = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_READ = 3'd3;
	localparam logic [2:0] OP_ACK = 3'd4;
	localparam logic [2:0] OP_NACK = 3'd5;
	localparam logic [2:0] OP_WAIT_ACK = 3'd6;
	localparam logic [2:0] OP_IDLE = 3'd7;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SETUP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

	localparam logic [9:0] SETUP_RESET = 10'd5;
	localparam logic [9:0] HOLD_RESET = 10'd4;
	localparam logic [7:0] TIMEOUT_RESET = 8'd255;

	typedef struct packed {
		logic       is_cmd;
		logic [2:0] command;
		logic [7:0] write_data;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic [9:0] setup_ticks;
		logic [9:0] hold_ticks;
		logic [7:0] ack_timeout;
	} cfg_t;

endpackage

// ===== rtl/i2c_master_bit_sequencer.sv =====
// Top level of the I2C master bit sequencer: registers, front queue and sequencer.
// Every input beat (a timing tick or a command) yields exactly one result beat carrying
// the SCL/SDA levels, busy, done, the last read byte, the last ack outcome and a
// rejected-command flag. An accepted beat is written into the input queue, from which the
// sequencer takes it into the result register, where its result is offered until taken;
// while the result side does not stall, the sequencer takes one beat per clock, so one
// beat per cycle is sustained. The queue of
// QUEUE_DEPTH beats sits between the input and the sequencer and absorbs stalls on the
// result side; input is refused only when it is full. Bus timing counts ticks, not
// clocks. Registers take effect on the clock after a write and should be written
// while the block is idle.
`include "i2c_master_bit_sequencer_defines.svh"

module i2c_master_bit_sequencer import i2cbs_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // command[2:0], write_data[10:3], sda_in[11]
	input  logic                  s_tuser,  // kind: 0 tick, 1 command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// scl[0], sda_out[1], busy_res[2], done_res[3], read_data[11:4], ack_ok[12],
	// cmd_error[13]
	output logic [M_TDATA_W-1:0]  m_tdata
);

	cfg_t  cfg_q;
	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setup_ticks <= SETUP_RESET;
			cfg_q.hold_ticks <= HOLD_RESET;
			cfg_q.ack_timeout <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SETUP: cfg_q.setup_ticks <= cfg_wdata;
				CFG_HOLD: cfg_q.hold_ticks <= cfg_wdata;
				CFG_TIMEOUT: cfg_q.ack_timeout <= cfg_wdata[7:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	i2cbs_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	i2cbs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	`I2CBS_ASSERT_IMPL(a_done_not_busy, m_tvalid && m_tdata[3], !m_tdata[2], "done while busy")
	`I2CBS_ASSERT_IMPL(a_err_busy, m_tvalid && m_tdata[13], m_tdata[2], "error while idle")
	`I2CBS_ASSERT_IMPL(a_full_stalled, !s_tready, m_tvalid, "queue full without result")
	`I2CBS_ASSERT_NEXT(a_full_holds, !s_tready && !m_tready, !s_tready, "queue drained in stall")

endmodule

// ===== rtl/i2cbs_front.sv =====
// Input side: unpacks and classifies beats and holds them in a short queue.
module i2cbs_front import i2cbs_pkg::*; #(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // command[2:0], write_data[10:3], sda_in[11]
	input  logic                 s_tuser,   // kind: 0 tick, 1 command
	output logic                 q_valid,
	output item_t                q_item,
	input  logic                 q_pop
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	item_t          in_item;
	logic           push;

	always_comb begin
		in_item.is_cmd = s_tuser;
		in_item.command = s_tdata[2:0];
		in_item.write_data = s_tdata[10:3];
		in_item.sda_in = s_tdata[11];
	end

	assign s_tready = (count_q != CW'(DEPTH));
	assign push = s_tvalid && s_tready;
	assign q_valid = (count_q != '0);
	assign q_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/i2cbs_back.sv =====
// Execution side: the bus sequencer and the registered result beat.
module i2cbs_back import i2cbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 q_valid,
	input  item_t                q_item,
	output logic                 q_pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam logic [1:0] PH_LOW = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_TAIL = 2'd2;

	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic [2:0] op_q, op_d;
	logic [1:0] phase_q, phase_d;
	logic [3:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d;
	logic [9:0] delay_q, delay_d;
	logic [7:0] tmo_q, tmo_d;
	logic       ack_q, ack_d;
	logic [7:0] read_q, read_d;
	logic       done, err, expired;
	logic [9:0] delay_dec;
	logic       m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	assign expired = (delay_q <= 10'd1);
	assign delay_dec = expired ? '0 : delay_q - 10'd1;

	always_comb begin
		scl_d = scl_q;
		sda_d = sda_q;
		op_d = op_q;
		phase_d = phase_q;
		bit_d = bit_q;
		shift_d = shift_q;
		delay_d = delay_q;
		tmo_d = tmo_q;
		ack_d = ack_q;
		read_d = read_q;
		done = 1'b0;
		err = 1'b0;
		if (q_item.is_cmd) begin
			if (op_q != OP_IDLE) begin
				err = 1'b1;
			end else if (q_item.command != OP_IDLE) begin
				op_d = q_item.command;
				phase_d = PH_LOW;
				bit_d = '0;
				case (q_item.command)
					OP_START: begin
						scl_d = 1'b1;
						sda_d = 1'b1;
						delay_d = cfg.setup_ticks;
					end
					OP_WRITE: begin
						shift_d = q_item.write_data;
						scl_d = 1'b0;
						sda_d = q_item.write_data[7];
					end
					default: begin
						if (q_item.command == OP_READ) begin
							shift_d = '0;
						end
						scl_d = 1'b0;
						sda_d = !(q_item.command == OP_STOP || q_item.command == OP_ACK);
					end
				endcase
			end
		end else if (op_q != OP_IDLE) begin
			case (op_q)
				OP_START: begin
					delay_d = delay_dec;
					if (expired) begin
						if (phase_q == PH_LOW) begin
							sda_d = 1'b0;
							delay_d = cfg.hold_ticks;
							phase_d = PH_HIGH;
						end else begin
							scl_d = 1'b0;
							done = 1'b1;
						end
					end
				end
				OP_STOP: begin
					if (phase_q == PH_LOW) begin
						scl_d = 1'b1;
						delay_d = cfg.hold_ticks;
						phase_d = PH_HIGH;
					end else begin
						delay_d = delay_dec;
						if (expired) begin
							if (phase_q == PH_HIGH) begin
								sda_d = 1'b1;
								delay_d = cfg.setup_ticks;
								phase_d = PH_TAIL;
							end else begin
								done = 1'b1;
							end
						end
					end
				end
				OP_WRITE, OP_READ: begin
					if (phase_q == PH_LOW) begin
						scl_d = 1'b1;
						delay_d = cfg.hold_ticks;
						phase_d = PH_HIGH;
					end else begin
						delay_d = delay_dec;
						if (expired) begin
							// Read data is sampled on the last SCL-high tick of each bit.
							shift_d = {shift_q[6:0], (op_q == OP_READ) && q_item.sda_in};
							scl_d = 1'b0;
							bit_d = bit_q + 4'd1;
							if (bit_d >= 4'd8) begin
								if (op_q == OP_READ) begin
									read_d = shift_d;
								end
								done = 1'b1;
							end else begin
								sda_d = (op_q == OP_WRITE) ? shift_d[7] : 1'b1;
								phase_d = PH_LOW;
							end
						end
					end
				end
				OP_ACK, OP_NACK: begin
					if (phase_q == PH_LOW) begin
						scl_d = 1'b1;
						delay_d = cfg.hold_ticks;
						phase_d = PH_HIGH;
					end else begin
						delay_d = delay_dec;
						if (expired) begin
							scl_d = 1'b0;
							sda_d = 1'b1;
							done = 1'b1;
						end
					end
				end
				OP_WAIT_ACK: begin
					if (phase_q == PH_LOW) begin
						scl_d = 1'b1;
						tmo_d = cfg.ack_timeout;
						phase_d = PH_HIGH;
					end else if (!q_item.sda_in) begin
						ack_d = 1'b1;
						scl_d = 1'b0;
						done = 1'b1;
					end else if (tmo_q <= 8'd1) begin
						tmo_d = '0;
						ack_d = 1'b0;
						scl_d = 1'b0;
						done = 1'b1;
					end else begin
						tmo_d = tmo_q - 8'd1;
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
			if (done) begin
				op_d = OP_IDLE;
				phase_d = PH_LOW;
			end
		end
	end

	// The sequencer steps whenever the result register is free or being emptied.
	assign q_pop = q_valid && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			op_q <= OP_IDLE;
			phase_q <= PH_LOW;
			bit_q <= '0;
			shift_q <= '0;
			delay_q <= '0;
			tmo_q <= '0;
			ack_q <= 1'b0;
			read_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				scl_q <= scl_d;
				sda_q <= sda_d;
				op_q <= op_d;
				phase_q <= phase_d;
				bit_q <= bit_d;
				shift_q <= shift_d;
				delay_q <= delay_d;
				tmo_q <= tmo_d;
				ack_q <= ack_d;
				read_q <= read_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			m_tdata_q <= {2'b00, err, ack_d, read_d, done, (op_d != OP_IDLE), sda_d, scl_d};
		end
	end

endmodule

// ===== verif/i2cbs_checker.sv =====
// Checker for the I2C bit sequencer: predicts every result beat and compares it field by field.
`timescale 1ns / 1ps
module i2cbs_checker import i2cbs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata,
	output int                    mismatches,
	output int                    outstanding,
	output logic                  seq_busy
);

	// Same layout as the low 14 bits of m_tdata.
	typedef struct packed {
		logic       cmd_error;
		logic       ack_ok;
		logic [7:0] read_data;
		logic       done;
		logic       busy;
		logic       sda_out;
		logic       scl;
	} bus_result_t;

	logic [9:0] setup_cfg;
	logic [9:0] hold_cfg;
	logic [7:0] timeout_cfg;

	logic       scl_lvl;
	logic       sda_lvl;
	logic [2:0] cur_op;
	logic [2:0] step;
	logic [3:0] bit_cnt;
	logic [7:0] shift_reg;
	logic [7:0] read_byte;
	logic [9:0] delay_cnt;
	logic [7:0] wait_cnt;
	logic       acked;
	logic       op_done;

	bus_result_t expected_results[$];

	function automatic logic delay_elapsed();
		if (delay_cnt <= 10'd1) begin
			delay_cnt = '0;
			return 1'b1;
		end
		delay_cnt = delay_cnt - 10'd1;
		return 1'b0;
	endfunction

	function automatic void end_op();
		cur_op = OP_IDLE;
		step = '0;
		op_done = 1'b1;
	endfunction

	function automatic void advance_bus(input logic sda);
		case (cur_op)
			OP_START: begin
				if (step == 3'd0) begin
					if (delay_elapsed()) begin
						sda_lvl = 1'b0;
						delay_cnt = hold_cfg;
						step = 3'd1;
					end
				end else if (delay_elapsed()) begin
					scl_lvl = 1'b0;
					end_op();
				end
			end
			OP_STOP: begin
				if (step == 3'd0) begin
					scl_lvl = 1'b1;
					delay_cnt = hold_cfg;
					step = 3'd1;
				end else if (step == 3'd1) begin
					if (delay_elapsed()) begin
						sda_lvl = 1'b1;
						delay_cnt = setup_cfg;
						step = 3'd2;
					end
				end else if (delay_elapsed()) begin
					end_op();
				end
			end
			OP_WRITE, OP_READ: begin
				if (step == 3'd0) begin
					scl_lvl = 1'b1;
					delay_cnt = hold_cfg;
					step = 3'd1;
				end else if (delay_elapsed()) begin
					shift_reg = {shift_reg[6:0], (cur_op == OP_READ) ? sda : 1'b0};
					scl_lvl = 1'b0;
					bit_cnt = bit_cnt + 4'd1;
					if (bit_cnt >= 4'd8) begin
						if (cur_op == OP_READ)
							read_byte = shift_reg;
						end_op();
					end else begin
						sda_lvl = (cur_op == OP_WRITE) ? shift_reg[7] : 1'b1;
						step = 3'd0;
					end
				end
			end
			OP_ACK, OP_NACK: begin
				if (step == 3'd0) begin
					scl_lvl = 1'b1;
					delay_cnt = hold_cfg;
					step = 3'd1;
				end else if (delay_elapsed()) begin
					scl_lvl = 1'b0;
					sda_lvl = 1'b1;
					end_op();
				end
			end
			OP_WAIT_ACK: begin
				if (step == 3'd0) begin
					scl_lvl = 1'b1;
					wait_cnt = timeout_cfg;
					step = 3'd1;
				end else if (!sda) begin
					acked = 1'b1;
					scl_lvl = 1'b0;
					end_op();
				end else if (wait_cnt <= 8'd1) begin
					wait_cnt = '0;
					acked = 1'b0;
					scl_lvl = 1'b0;
					end_op();
				end else begin
					wait_cnt = wait_cnt - 8'd1;
				end
			end
			default: end_op();
		endcase
	endfunction

	function automatic bus_result_t predict_bus_step(input item_t beat);
		bus_result_t res;
		res = '0;
		op_done = 1'b0;
		if (beat.is_cmd) begin
			if (cur_op != OP_IDLE) begin
				res.cmd_error = 1'b1;
			end else if (beat.command != OP_IDLE) begin
				cur_op = beat.command;
				step = '0;
				bit_cnt = '0;
				case (beat.command)
					OP_START: begin
						scl_lvl = 1'b1;
						sda_lvl = 1'b1;
						delay_cnt = setup_cfg;
					end
					OP_WRITE: begin
						shift_reg = beat.write_data;
						scl_lvl = 1'b0;
						sda_lvl = beat.write_data[7];
					end
					default: begin
						if (beat.command == OP_READ)
							shift_reg = '0;
						scl_lvl = 1'b0;
						sda_lvl = !(beat.command == OP_STOP || beat.command == OP_ACK);
					end
				endcase
			end
		end else if (cur_op != OP_IDLE) begin
			advance_bus(beat.sda_in);
		end
		res.scl = scl_lvl;
		res.sda_out = sda_lvl;
		res.busy = (cur_op != OP_IDLE);
		res.done = op_done;
		res.read_data = read_byte;
		res.ack_ok = acked;
		return res;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t       beat;
		bus_result_t want;
		bus_result_t got;
		if (!arst_n) begin
			setup_cfg = SETUP_RESET;
			hold_cfg = HOLD_RESET;
			timeout_cfg = TIMEOUT_RESET;
			scl_lvl = 1'b1;
			sda_lvl = 1'b1;
			cur_op = OP_IDLE;
			step = '0;
			bit_cnt = '0;
			shift_reg = '0;
			read_byte = '0;
			delay_cnt = '0;
			wait_cnt = '0;
			acked = 1'b0;
			expected_results.delete();
			mismatches = 0;
			outstanding = 0;
			seq_busy = 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SETUP:   setup_cfg = cfg_wdata;
					CFG_HOLD:    hold_cfg = cfg_wdata;
					CFG_TIMEOUT: timeout_cfg = cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				beat.is_cmd = s_tuser;
				beat.command = s_tdata[2:0];
				beat.write_data = s_tdata[10:3];
				beat.sda_in = s_tdata[11];
				expected_results.push_back(predict_bus_step(beat));
			end
			if (m_tvalid && m_tready) begin
				got = bus_result_t'(m_tdata[13:0]);
				if (expected_results.size() == 0) begin
					$error("result beat arrived with no prediction waiting");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("scl", want.scl, got.scl);
					check_field("sda_out", want.sda_out, got.sda_out);
					check_field("busy_res", want.busy, got.busy);
					check_field("done_res", want.done, got.done);
					check_field("read_data", want.read_data, got.read_data);
					check_field("ack_ok", want.ack_ok, got.ack_ok);
					check_field("cmd_error", want.cmd_error, got.cmd_error);
				end
			end
			outstanding = expected_results.size();
			seq_busy = (cur_op != OP_IDLE);
		end
	end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the I2C bit sequencer: clock, reset, register setup, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
	import i2cbs_pkg::*;

	localparam int StallLimit = 2000;
	localparam int SdaLow = 0;
	localparam int SdaHigh = 1;
	localparam int SdaRandom = 2;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;   // command[2:0], write_data[10:3], sda_in[11]
	logic                  s_tuser;   // kind: 0 tick, 1 command
	logic                  m_tvalid;
	logic                  m_tready;
	// scl[0], sda_out[1], busy_res[2], done_res[3], read_data[11:4], ack_ok[12],
	// cmd_error[13]
	logic [M_TDATA_W-1:0]  m_tdata;

	int   mismatches;
	int   outstanding;
	logic seq_busy;

	int snd_idle_pct;
	int rcv_idle_pct;
	int snd_calm;
	int rcv_calm;
	int stall_cycles;

	i2c_master_bit_sequencer dut (.*);
	i2cbs_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver stalls at random, with occasional stretches of steady readiness.
	always @(negedge clk) begin
		if (rcv_calm != 0)
			rcv_calm--;
		else if ($urandom_range(0, 99) == 0)
			rcv_calm = $urandom_range(20, 80);
		m_tready = (rcv_calm != 0) || ($urandom_range(0, 99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= StallLimit) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic send_beat(input logic is_cmd, input logic [2:0] cmd,
			input logic [7:0] wd, input logic sda);
		if (snd_calm != 0) begin
			snd_calm--;
		end else if ($urandom_range(0, 99) == 0) begin
			snd_calm = $urandom_range(20, 80);
		end else if ($urandom_range(0, 99) < snd_idle_pct) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = is_cmd;
		s_tdata = {4'b0, sda, wd, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic pick_sda(input int mode);
		if (mode == SdaLow)
			return 1'b0;
		if (mode == SdaHigh)
			return 1'b1;
		// Mostly released, so that ack waits both succeed and time out.
		return ($urandom_range(0, 99) < 85);
	endfunction

	task automatic send_tick(input int mode);
		send_beat(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), pick_sda(mode));
	endtask

	task automatic run_op(input logic [2:0] cmd, input logic [7:0] wd, input int mode);
		send_beat(1'b1, cmd, wd, 1'($urandom));
		while (seq_busy) send_tick(mode);
	endtask

	task automatic wait_results_drained();
		s_tvalid = 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	task automatic settle_bus();
		while (seq_busy) send_tick(SdaRandom);
		wait_results_drained();
	endtask

	task automatic apply_timing(input logic [9:0] setup, input logic [9:0] hold,
			input logic [7:0] timeout);
		cfg_we = 1'b1;
		cfg_index = CFG_SETUP;
		cfg_wdata = setup;
		@(negedge clk);
		cfg_index = CFG_HOLD;
		cfg_wdata = hold;
		@(negedge clk);
		cfg_index = CFG_TIMEOUT;
		cfg_wdata = {2'b0, timeout};
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Mostly whole command sequences; the rest are rejected or ignored commands and idle ticks.
	task automatic drive_random(input int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 59) == 0)
				wait_results_drained();
			pick = $urandom_range(0, 99);
			if (seq_busy) begin
				if (pick < 93)
					send_tick(SdaRandom);
				else
					send_beat(1'b1, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
			end else if (pick < 80) begin
				send_beat(1'b1, 3'($urandom_range(OP_START, OP_WAIT_ACK)), 8'($urandom),
					1'($urandom));
			end else if (pick < 86) begin
				send_beat(1'b1, OP_IDLE, 8'($urandom), 1'($urandom));
			end else begin
				send_tick(SdaRandom);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SETUP;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		stall_cycles = 0;
		snd_calm = 0;
		rcv_calm = 0;
		snd_idle_pct = 14;
		rcv_idle_pct = 55;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		apply_timing(10'd1, 10'd1, 8'd1);
		// Idle tick, the unused command code, and a command rejected in mid start.
		send_tick(SdaHigh);
		send_beat(1'b1, OP_IDLE, 8'h00, 1'b0);
		send_beat(1'b1, OP_START, 8'h00, 1'b1);
		send_beat(1'b1, OP_READ, 8'hFF, 1'b1);
		while (seq_busy) send_tick(SdaHigh);
		run_op(OP_WRITE, 8'hFF, SdaLow);
		run_op(OP_READ, 8'h00, SdaHigh);
		run_op(OP_WAIT_ACK, 8'h00, SdaLow);
		run_op(OP_WAIT_ACK, 8'h00, SdaHigh);
		run_op(OP_ACK, 8'h00, SdaHigh);
		run_op(OP_NACK, 8'h00, SdaHigh);
		run_op(OP_STOP, 8'h00, SdaHigh);
		drive_random(130);
		settle_bus();

		snd_idle_pct = 55;
		rcv_idle_pct = 14;
		apply_timing(10'd0, 10'd0, 8'd0);
		drive_random(60);
		settle_bus();
		apply_timing(10'd3, 10'd2, 8'd20);
		drive_random(120);
		settle_bus();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		apply_timing(10'd20, 10'd6, 8'd12);
		run_op(OP_START, 8'h00, SdaRandom);
		run_op(OP_WRITE, 8'($urandom), SdaRandom);
		run_op(OP_WAIT_ACK, 8'h00, SdaHigh);
		run_op(OP_READ, 8'h00, SdaRandom);
		run_op(OP_NACK, 8'h00, SdaRandom);
		run_op(OP_STOP, 8'h00, SdaRandom);
		wait_results_drained();
		apply_timing(10'd2, 10'd3, 8'd5);
		drive_random(70);
		settle_bus();

		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
